/* rtl/filterbank_header_parser_assert.svh */
`ifndef FILTERBANK_HEADER_PARSER_ASSERT_SVH
`define FILTERBANK_HEADER_PARSER_ASSERT_SVH
// Assert that a condition implies a property on the next edge.
`define FHP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
// Assert a combinational implication.
`define FHP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`endif

/* rtl/fhp_pkg.sv */
package fhp_pkg;
  typedef enum logic [2:0] {
    PH_IDLE, PH_KLEN, PH_KBODY, PH_INT, PH_DBL, PH_SLEN, PH_SBODY, PH_DONE
  } phase_t;

  // Value kind that follows a matched field name
  typedef enum logic [1:0] {NK_INT, NK_DBL, NK_STR} name_kind_t;

  localparam logic [2:0] EV_INT    = 3'd0;
  localparam logic [2:0] EV_DBL    = 3'd1;
  localparam logic [2:0] EV_CHR    = 3'd2;
  localparam logic [2:0] EV_SEND   = 3'd3;
  localparam logic [2:0] EV_HEND   = 3'd4;
  localparam logic [2:0] EV_NOTHDR = 3'd5;
  localparam logic [2:0] EV_LERR   = 3'd6;

  localparam int MAX_STRING_KEEP  = 79;
  localparam int MAX_KEYWORD_LEN  = 255;
  localparam int MAX_HEADER_BYTES = 4096;
  localparam int NUM_NAMES = 21;
  localparam int NAME_MAX  = 13;
  localparam int START_LEN = 12;

  // Start mark text, byte 0 first.
  localparam logic [START_LEN*8-1:0] START_TEXT = "TRATS_REDAEH";

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  field;
    logic [63:0] value;
    logic [7:0]  idx;
    logic        last;
  } result_t;

  // Name text as 13 bytes, byte 0 first; unused bytes are never compared.
  typedef logic [NAME_MAX*8-1:0] name_text_t;

  function automatic logic [7:0] name_byte(input logic [4:0] k, input logic [3:0] p);
    name_text_t t;
    unique case (k)
      5'd0:  t = {8'h0, 8'h0, 8'h0, "DNE_REDAEH"};
      5'd1:  t = {8'h0, 8'h0, 8'h0, "di_enihcam"};
      5'd2:  t = {8'h0, "di_epocselet"};
      5'd3:  t = {8'h0, 8'h0, 8'h0, 8'h0, "epyt_atad"};
      5'd4:  t = {8'h0, 8'h0, "cirtnecyrab"};
      5'd5:  t = "cirtnecraslup";
      5'd6:  t = {48'h0, "jar_crs"};
      5'd7:  t = {48'h0, "jed_crs"};
      5'd8:  t = {40'h0, "trats_za"};
      5'd9:  t = {40'h0, "trats_az"};
      5'd10: t = {72'h0, "1hcf"};
      5'd11: t = {72'h0, "ffof"};
      5'd12: t = {56'h0, "snahcn"};
      5'd13: t = {56'h0, "smaebn"};
      5'd14: t = {64'h0, "maebi"};
      5'd15: t = {64'h0, "stibn"};
      5'd16: t = {56'h0, "tratst"};
      5'd17: t = {64'h0, "pmast"};
      5'd18: t = {72'h0, "sfin"};
      5'd19: t = {8'h0, 8'h0, "eman_ecruos"};
      5'd20: t = {8'h0, 8'h0, "elifatadwar"};
      default: t = '0;
    endcase
    return t[p*8 +: 8];
  endfunction

  function automatic logic [3:0] name_len(input logic [4:0] k);
    unique case (k)
      5'd0, 5'd1: return 4'd10;
      5'd2: return 4'd12;
      5'd3: return 4'd9;
      5'd4, 5'd19, 5'd20: return 4'd11;
      5'd5: return 4'd13;
      5'd6, 5'd7: return 4'd7;
      5'd8, 5'd9: return 4'd8;
      5'd10, 5'd11, 5'd18: return 4'd4;
      5'd12, 5'd13, 5'd16: return 4'd6;
      default: return 4'd5;
    endcase
  endfunction

  function automatic name_kind_t name_kind(input logic [4:0] k);
    if ((k >= 5'd6 && k <= 5'd11) || k == 5'd16 || k == 5'd17) return NK_DBL;
    if (k == 5'd19 || k == 5'd20) return NK_STR;
    return NK_INT;
  endfunction
endpackage

/* rtl/fhp_match.sv */
module fhp_match (
  input  logic [7:0]  data_byte,
  input  logic [31:0] pos,
  input  logic        first,
  input  logic [20:0] vec_in,
  output logic [20:0] vec_out
);
  import fhp_pkg::*;
  always_comb begin
    vec_out = vec_in;
    for (int k = 0; k < NUM_NAMES; k++) begin
      if (first) begin
        if (k == 0 && !(pos < START_LEN && START_TEXT[pos[3:0]*8 +: 8] == data_byte))
          vec_out[0] = 1'b0;
      end else if (!(pos < {28'h0, name_len(5'(k))} &&
                     name_byte(5'(k), pos[3:0]) == data_byte)) begin
        vec_out[k] = 1'b0;
      end
    end
  end
endmodule

/* rtl/filterbank_header_parser.sv */
// Output: a result is registered into the output register, or into the skid
// slot while out_ready is low, as the byte that causes it is accepted.
// Throughput: one byte per cycle while the skid slot is empty; the output
// register with a skid stage lets a new byte enter while a result waits for out_ready.
// Reset: synchronous active-low rst_n; parser idles until start_of_header.
module filterbank_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_header,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [4:0]  out_field_code,
  output logic [63:0] out_value,
  output logic [7:0]  out_char_index,
  output logic        out_last_char
);
  import fhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt, len_r, len_nxt;
  logic [20:0] vec_r, vec_nxt, vec_m;
  logic [63:0] shf_r, shf_nxt;
  logic [4:0]  fld_r, fld_nxt;
  logic [12:0] hbc_r, hbc_nxt;
  logic        first_r, first_nxt;
  logic        emit;
  result_t     res;
  result_t     out_r, skid_r;
  logic        ov_r, sv_r;

  // cnt_nxt etc. are built in two steps: restart first, then the byte.
  phase_t      ph0;
  logic [31:0] c0, l0;
  logic [20:0] v0;
  logic [63:0] s0;
  logic [12:0] h0;
  logic        f0;
  logic [31:0] pos, keep, bcnt;
  logic [63:0] sh;

  // Hold input while the skid slot is occupied.
  assign in_ready = !sv_r;
  wire take = in_valid && in_ready;

  // The match unit sees the post-restart byte position.
  fhp_match u_match (
    .data_byte(in_data_byte), .pos(c0), .first(f0),
    .vec_in(v0), .vec_out(vec_m)
  );

  always_comb begin
    ph0 = phase_r; c0 = cnt_r; l0 = len_r; v0 = vec_r; s0 = shf_r; h0 = hbc_r;
    f0 = first_r;
    fld_nxt = fld_r;
    if (in_start_of_header) begin
      ph0 = PH_KLEN; c0 = '0; l0 = '0; v0 = '1; s0 = '0; h0 = '0; f0 = 1'b1;
      fld_nxt = '0;
    end
    phase_nxt = ph0; cnt_nxt = c0; len_nxt = l0; vec_nxt = v0; shf_nxt = s0;
    hbc_nxt = h0; first_nxt = f0;
    emit = 1'b0; res = '0;
    pos = c0; bcnt = c0 + 32'd1;
    sh = s0 | ({56'h0, in_data_byte} << {c0[2:0], 3'b000});
    keep = (l0 < MAX_STRING_KEEP) ? l0 : 32'(MAX_STRING_KEEP);
    if (ph0 != PH_IDLE && ph0 != PH_DONE) begin
      if (h0 >= 13'(MAX_HEADER_BYTES)) begin
        phase_nxt = PH_DONE; emit = 1'b1;
        res = '{EV_LERR, 5'd0, {51'h0, h0}, 8'd0, 1'b0};
      end else begin
        hbc_nxt = h0 + 13'd1;
        unique case (ph0)
          PH_KLEN, PH_SLEN, PH_INT, PH_DBL: begin
            shf_nxt = sh; cnt_nxt = bcnt;
            if (bcnt == ((ph0 == PH_DBL) ? 32'd8 : 32'd4)) begin
              cnt_nxt = '0; shf_nxt = '0; phase_nxt = PH_KLEN;
              if (ph0 == PH_INT) begin
                emit = 1'b1; res = '{EV_INT, fld_r, {32'h0, sh[31:0]}, 8'd0, 1'b0};
              end else if (ph0 == PH_DBL) begin
                emit = 1'b1; res = '{EV_DBL, fld_r, sh, 8'd0, 1'b0};
              end else begin
                len_nxt = sh[31:0];
                if (ph0 == PH_SLEN) begin
                  if (sh[31]) begin
                    phase_nxt = PH_DONE; emit = 1'b1;
                    res = '{EV_LERR, 5'd0, {51'h0, hbc_nxt}, 8'd0, 1'b0};
                  end else if (sh[31:0] == 0) begin
                    emit = 1'b1; res = '{EV_SEND, fld_r, 64'd0, 8'd0, 1'b1};
                  end else phase_nxt = PH_SBODY;
                end else begin
                  vec_nxt = '1;
                  if (f0 && sh[31:0] > START_LEN) begin
                    phase_nxt = PH_DONE; emit = 1'b1;
                    res = '{EV_NOTHDR, 5'd0, {51'h0, hbc_nxt}, 8'd0, 1'b0};
                  end else if (!f0 && sh[31:0] > MAX_KEYWORD_LEN) begin
                    phase_nxt = PH_DONE; emit = 1'b1;
                    res = '{EV_LERR, 5'd0, {51'h0, hbc_nxt}, 8'd0, 1'b0};
                  end else if (sh[31:0] == 0) begin
                    if (f0) first_nxt = 1'b0;
                    else begin
                      phase_nxt = PH_DONE; emit = 1'b1;
                      res = '{EV_HEND, 5'd0, {51'h0, hbc_nxt}, 8'd0, 1'b0};
                    end
                  end else phase_nxt = PH_KBODY;
                end
              end
            end
          end
          PH_KBODY: begin
            cnt_nxt = bcnt;
            vec_nxt = vec_m;
            if (bcnt >= l0) begin
              cnt_nxt = '0; shf_nxt = '0; phase_nxt = PH_KLEN;
              if (f0) begin
                first_nxt = 1'b0;
                if (!vec_m[0]) begin
                  phase_nxt = PH_DONE; emit = 1'b1;
                  res = '{EV_NOTHDR, 5'd0, {51'h0, hbc_nxt}, 8'd0, 1'b0};
                end
              end else if (vec_m[0]) begin
                phase_nxt = PH_DONE; emit = 1'b1;
                res = '{EV_HEND, 5'd0, {51'h0, hbc_nxt}, 8'd0, 1'b0};
              end else begin
                // Take the lowest matching field.
                for (int k = NUM_NAMES - 1; k >= 1; k--) begin
                  if (vec_m[k]) begin
                    fld_nxt = 5'(k - 1);
                    unique case (name_kind(5'(k)))
                      NK_INT: phase_nxt = PH_INT;
                      NK_DBL: phase_nxt = PH_DBL;
                      default: phase_nxt = PH_SLEN;
                    endcase
                  end
                end
              end
            end
          end
          PH_SBODY: begin
            cnt_nxt = bcnt;
            if (pos < keep) begin
              emit = 1'b1;
              res = '{EV_CHR, fld_r, {56'h0, in_data_byte}, pos[7:0], bcnt == l0};
              if (bcnt == l0) begin
                cnt_nxt = '0; phase_nxt = PH_KLEN;
              end
            end else if (bcnt == l0) begin
              emit = 1'b1; res = '{EV_SEND, fld_r, {32'h0, keep}, 8'd0, 1'b1};
              cnt_nxt = '0; phase_nxt = PH_KLEN;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; cnt_r <= '0; len_r <= '0; vec_r <= '1; shf_r <= '0;
      fld_r <= '0; hbc_r <= '0; first_r <= 1'b0; ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; cnt_r <= cnt_nxt; len_r <= len_nxt;
        vec_r <= vec_nxt; shf_r <= shf_nxt; fld_r <= fld_nxt; hbc_r <= hbc_nxt;
        first_r <= first_nxt;
      end
      // Output register plus one skid slot; input is held while the slot is full.
      if (ov_r && !out_ready) begin
        if (take && emit) begin
          sv_r <= 1'b1; skid_r <= res;
        end
      end else if (sv_r) begin
        out_r <= skid_r; sv_r <= 1'b0;
      end else begin
        ov_r <= take && emit;
        if (take && emit) out_r <= res;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_event_kind = out_r.kind;
  assign out_field_code = out_r.field;
  assign out_value      = out_r.value;
  assign out_char_index = out_r.idx;
  assign out_last_char  = out_r.last;
endmodule

/* rtl/fhp_checker.sv */
module fhp_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_kind,
  input logic [63:0] out_value,
  input logic [7:0]  out_char_index,
  input logic        out_last_char
);
  import fhp_pkg::*;
  `include "filterbank_header_parser_assert.svh"
  `FHP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_value))
  `FHP_ASSERT_NOW(a_kind, out_valid, out_event_kind <= EV_LERR)
  `FHP_ASSERT_NOW(a_last, out_valid && out_last_char, out_event_kind == EV_CHR || out_event_kind == EV_SEND)
  `FHP_ASSERT_NOW(a_idx, out_valid && out_event_kind == EV_CHR, out_char_index < MAX_STRING_KEEP)
  `FHP_ASSERT_NOW(a_ready, !in_ready, out_valid)
endmodule

bind filterbank_header_parser fhp_props u_fhp_props (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_event_kind(out_event_kind),
  .out_value(out_value), .out_char_index(out_char_index), .out_last_char(out_last_char)
);

/* dv/fhp_checker.sv */
module fhp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_header,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_event_kind,
  input  logic [4:0]  out_field_code,
  input  logic [63:0] out_value,
  input  logic [7:0]  out_char_index,
  input  logic        out_last_char,
  output int          fails,
  output int          pending,
  output int          n_results
);
  import fhp_pkg::*;

  // Parser state mirror
  phase_t      ph;
  logic [31:0] cnt;
  logic [31:0] lenw;
  logic [20:0] mvec;
  logic [63:0] shv;
  logic [4:0]  fld;
  logic [12:0] hcnt;
  bit          first_kw;

  result_t exp_events[$];

  function automatic string join_text(string a, string b);
    return {a, b};
  endfunction

  function automatic string kw_text(int k);
    case (k)
      0: return join_text("HEADER", "_END");
      1: return join_text("machine", "_id");
      2: return join_text("telescope", "_id");
      3: return join_text("data", "_type");
      4: return "barycentric";    5: return "pulsarcentric";
      6: return "src_raj";        7: return "src_dej";
      8: return join_text("az", "_start");
      9: return join_text("za", "_start");
      10: return "fch1";          11: return "foff";
      12: return "nchans";        13: return "nbeams";      14: return "ibeam";
      15: return "nbits";         16: return "tstart";      17: return "tsamp";
      18: return "nifs";
      19: return join_text("source", "_name");
      default: return "rawdatafile";
    endcase
  endfunction

  function automatic name_kind_t kw_kind(int k);
    if ((k >= 6 && k <= 11) || k == 16 || k == 17) return NK_DBL;
    if (k >= 19) return NK_STR;
    return NK_INT;
  endfunction

  task automatic clear_state();
    ph = PH_IDLE; cnt = '0; lenw = '0; mvec = '1; shv = '0;
    fld = '0; hcnt = '0; first_kw = 0;
  endtask

  task automatic next_elem(phase_t p);
    ph = p; cnt = '0; shv = '0;
  endtask

  task automatic push_ev(logic [2:0] k, logic [4:0] f, logic [63:0] v, logic [7:0] i,
                         logic l);
    result_t r;
    r.kind = k; r.field = f; r.value = v; r.idx = i; r.last = l;
    exp_events.push_back(r);
  endtask

  task automatic stop_with(logic [2:0] k);
    ph = PH_DONE;
    push_ev(k, 5'd0, {51'd0, hcnt}, 8'd0, 1'b0);
  endtask

  task automatic keyword_end();
    bit found;
    name_kind_t kd;
    found = 0;
    if (first_kw) begin
      first_kw = 0;
      if (!mvec[0]) stop_with(EV_NOTHDR);
      else next_elem(PH_KLEN);
      return;
    end
    if (mvec[0]) begin
      stop_with(EV_HEND);
      return;
    end
    for (int k = 1; k < NUM_NAMES; k++) begin
      if (!found && mvec[k]) begin
        found = 1;
        fld = 5'(k - 1);
        kd = kw_kind(k);
        if (kd == NK_INT) next_elem(PH_INT);
        else if (kd == NK_DBL) next_elem(PH_DBL);
        else next_elem(PH_SLEN);
      end
    end
    if (!found) next_elem(PH_KLEN);
  endtask

  // Advance the mirror by one header byte; queue any event it causes.
  task automatic parse_byte(logic [7:0] b, logic soh);
    logic [31:0] pos, keep;
    string nm;
    if (soh) begin
      clear_state();
      ph = PH_KLEN;
      first_kw = 1;
    end
    if (ph == PH_IDLE || ph == PH_DONE) return;
    if (hcnt >= MAX_HEADER_BYTES) begin
      stop_with(EV_LERR);
      return;
    end
    hcnt++;
    case (ph)
      PH_KLEN, PH_SLEN, PH_INT, PH_DBL: begin
        shv |= 64'(b) << ((8 * cnt) & 63);
        cnt++;
        if (cnt < (ph == PH_DBL ? 8 : 4)) return;
        if (ph == PH_INT) begin
          push_ev(EV_INT, fld, {32'd0, shv[31:0]}, 8'd0, 1'b0);
          next_elem(PH_KLEN);
          return;
        end
        if (ph == PH_DBL) begin
          push_ev(EV_DBL, fld, shv, 8'd0, 1'b0);
          next_elem(PH_KLEN);
          return;
        end
        lenw = shv[31:0];
        if (ph == PH_SLEN) begin
          if (lenw[31]) stop_with(EV_LERR);
          else if (lenw == 0) begin
            push_ev(EV_SEND, fld, 64'd0, 8'd0, 1'b1);
            next_elem(PH_KLEN);
          end else next_elem(PH_SBODY);
          return;
        end
        mvec = '1;
        if (first_kw) begin
          if (lenw > START_LEN) begin
            stop_with(EV_NOTHDR);
            return;
          end
        end else if (lenw > MAX_KEYWORD_LEN) begin
          stop_with(EV_LERR);
          return;
        end
        if (lenw == 0) keyword_end();
        else next_elem(PH_KBODY);
      end
      PH_KBODY: begin
        pos = cnt;
        if (first_kw) begin
          nm = join_text("HEADER_", "START");
          if (!(pos < START_LEN && nm[pos] == b)) mvec[0] = 1'b0;
        end else begin
          for (int k = 0; k < NUM_NAMES; k++) begin
            nm = kw_text(k);
            if (!(pos < nm.len() && nm[pos] == b)) mvec[k] = 1'b0;
          end
        end
        cnt++;
        if (cnt >= lenw) keyword_end();
      end
      PH_SBODY: begin
        pos = cnt;
        cnt++;
        keep = (lenw < MAX_STRING_KEEP) ? lenw : MAX_STRING_KEEP;
        if (pos < keep) begin
          push_ev(EV_CHR, fld, {56'd0, b}, pos[7:0], cnt == lenw);
          if (cnt == lenw) next_elem(PH_KLEN);
        end else if (cnt == lenw) begin
          push_ev(EV_SEND, fld, 64'(keep), 8'd0, 1'b1);
          next_elem(PH_KLEN);
        end
      end
      default: ph = PH_DONE;
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    fails++;
    if (fails <= 20)
      $display("mismatch %0s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      clear_state();
      fails = 0;
      n_results = 0;
    end else begin
      // results first: they come from bytes accepted at earlier edges
      if (out_valid && out_ready) begin
        n_results++;
        if (exp_events.size() == 0) begin
          report("unexpected result", {61'd0, out_event_kind}, 64'd0);
        end else begin
          w = exp_events.pop_front();
          if (out_event_kind !== w.kind) report("event_kind", 64'(out_event_kind), 64'(w.kind));
          if (out_field_code !== w.field) report("field_code", 64'(out_field_code), 64'(w.field));
          if (out_value !== w.value) report("value", out_value, w.value);
          if (out_char_index !== w.idx) report("char_index", 64'(out_char_index), 64'(w.idx));
          if (out_last_char !== w.last) report("last_char", 64'(out_last_char), 64'(w.last));
        end
      end
      if (in_valid && in_ready) parse_byte(in_data_byte, in_start_of_header);
    end
    pending = exp_events.size();
  end

endmodule

/* dv/tb.sv */
module tb;
  import fhp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_start_of_header = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_kind;
  logic [4:0]  out_field_code;
  logic [63:0] out_value;
  logic [7:0]  out_char_index;
  logic        out_last_char;

  int fails, pending, n_results;

  // Byte stream: {start_of_header, data byte}
  logic [8:0] hdr_bytes[$];
  int  n_directed;
  int  send_idx = 0;
  int  n_taken = 0;
  int  idle_left = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  hold_done = 0;
  bit  taken_now = 0;
  int  cycles = 0;

  always #10 clk = ~clk;

  filterbank_header_parser u_top (.*);

  fhp_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_start_of_header,
    .out_valid, .out_ready, .out_event_kind, .out_field_code, .out_value,
    .out_char_index, .out_last_char, .fails, .pending, .n_results
  );

  function automatic string join_text(string a, string b);
    return {a, b};
  endfunction

  function automatic string field_text(int k);
    case (k)
      0: return join_text("machine", "_id");
      1: return join_text("telescope", "_id");
      2: return join_text("data", "_type");
      3: return "barycentric";   4: return "pulsarcentric"; 5: return "src_raj";
      6: return "src_dej";
      7: return join_text("az", "_start");
      8: return join_text("za", "_start");
      9: return "fch1";          10: return "foff";         11: return "nchans";
      12: return "nbeams";       13: return "ibeam";        14: return "nbits";
      15: return "tstart";       16: return "tsamp";        17: return "nifs";
      18: return join_text("source", "_name");
      default: return "rawdatafile";
    endcase
  endfunction

  // Value kind by field code
  function automatic name_kind_t field_kind(int f);
    if ((f >= 5 && f <= 10) || f == 15 || f == 16) return NK_DBL;
    if (f >= 18) return NK_STR;
    return NK_INT;
  endfunction

  task automatic put(logic [7:0] b, bit soh = 0);
    hdr_bytes.push_back({soh, b});
  endtask

  task automatic put_word(logic [31:0] w, bit soh = 0);
    put(w[7:0], soh); put(w[15:8]); put(w[23:16]); put(w[31:24]);
  endtask

  task automatic put_kw(string s);
    put_word(s.len());
    foreach (s[i]) put(s[i]);
  endtask

  task automatic put_start(string s);
    put_word(s.len(), 1);
    foreach (s[i]) put(s[i]);
  endtask

  task automatic put_string(int n);
    put_word(n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  // Value body for a field; strings are short most of the time.
  task automatic put_value(int f);
    int sel;
    case (field_kind(f))
      NK_INT: put_word($urandom);
      NK_DBL: begin put_word($urandom); put_word($urandom); end
      default: begin
        sel = $urandom_range(0, 9);
        if (sel == 0) put_string(0);
        else if (sel == 1) put_string($urandom_range(78, 81));
        else if (sel == 2) put_string($urandom_range(82, 140));
        else put_string($urandom_range(1, 12));
      end
    endcase
  endtask

  task automatic put_field(int f);
    put_kw(field_text(f));
    put_value(f);
  endtask

  // One random header: mostly well-formed, with noise and broken endings.
  task automatic put_random_header();
    int n, sel, f, plen;
    string s, u;
    sel = $urandom_range(0, 19);
    if (sel == 0) put_start("HEADER_");
    else if (sel == 1) put_start("");
    else if (sel == 2) begin
      put_start("HEADXR_START");
      put_kw("nbits"); put_word(8);
      return;
    end else if (sel == 3) begin
      put_word($urandom_range(13, 300), 1);
      return;
    end else put_start(join_text("HEADER_", "START"));
    n = $urandom_range(1, 6);
    repeat (n) begin
      sel = $urandom_range(0, 9);
      f = $urandom_range(0, 19);
      if (sel < 7) put_field(f);
      else if (sel == 7) begin
        // prefix keyword: first matching name decides the value kind
        s = field_text(f);
        plen = $urandom_range(1, s.len());
        put_kw(s.substr(0, plen - 1));
        put_value(f);
      end else begin
        u = "";
        repeat ($urandom_range(1, 20)) u = {u, string'(8'($urandom_range(33, 126)))};
        put_kw(u);
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 5) put_kw(join_text("HEADER", "_END"));
    else if (sel == 5) put_word(0);
    else if (sel == 6) put_word($urandom_range(256, 70000) | ($urandom_range(0, 1) << 31));
    else if (sel == 7) begin
      put_kw(field_text(18 + $urandom_range(0, 1)));
      put_word(32'h8000_0000 | $urandom);
    end else if (sel == 8) put_kw("HEADER_");
    // else: no ending, the next start restarts the parser mid-header
    repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));  // trailing bytes, ignored if the header has ended
  endtask

  task automatic build_stream();
    // Ignored before any start
    put(8'hff); put(8'h00);
    // Extreme values, string edge lengths, unknown keyword
    put_start(join_text("HEADER_", "START"));
    put_kw("nbits"); put_word(32'hffff_ffff);
    put_kw("fch1"); put_word(32'h0); put_word(32'h7ff0_0000);
    put_kw(field_text(18)); put_string(80);
    put_kw("rawdatafile"); put_string(79);
    put_kw("unknown_kw");
    put_kw(join_text("HEADER", "_END"));
    // Empty keyword after start ends the header
    put_start(""); put_word(0);
    // Not a header: long first keyword, then bad text
    put_word(13, 1);
    put_start("HEADER_STARX");
    // Not a header: oversize or negative first keyword length, a field name as first keyword
    put_start(join_text("HEADER_", "START")); put_word(256);
    put_start(join_text("HEADER_", "START")); put_word(32'hffff_ffff);
    put_start(join_text("HEADER_", "START")); put_kw(field_text(18));
    put_word(32'h8000_0000);
    n_directed = hdr_bytes.size();
    while (hdr_bytes.size() < 450) put_random_header();
  endtask

  initial begin
    build_stream();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    taken_now <= in_valid && in_ready;
    if (in_valid && in_ready) n_taken <= n_taken + 1;
  end

  // Sender: hold the payload until taken, idle in bursts except near the end.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !taken_now) begin
        // hold
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        in_valid <= 1'b0;
      end else if (send_idx < hdr_bytes.size()) begin
        if (send_idx < hdr_bytes.size() - 100 && $urandom_range(0, 11) == 0) begin
          idle_left <= $urandom_range(1, 14) - 1;
          in_valid <= 1'b0;
        end else begin
          {in_start_of_header, in_data_byte} <= hdr_bytes[send_idx];
          in_valid <= 1'b1;
          send_idx <= send_idx + 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off early on so the block backs up, then random stalls.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && send_idx >= 40) begin
        hold_done <= 1;
        hold_left <= 200;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (send_idx < hdr_bytes.size() - 100 && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 14) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (rst_n);
    wait (hdr_bytes.size() > 0 && n_taken == hdr_bytes.size());
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d header bytes (%0d directed), %0d parser events checked",
             hdr_bytes.size(), n_directed, n_results);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/fhp_pkg.sv
rtl/fhp_match.sv
rtl/filterbank_header_parser.sv
rtl/fhp_checker.sv
dv/fhp_checker.sv
dv/tb.sv
